### rtl/pbe_pkg.sv
// Shared types, constants and conversion functions for the PCM block envelope.
`default_nettype none

package pbe_pkg;

    // Fixed-point format of converted samples (Q1.23)
    localparam int FRAC_BITS    = 23;
    localparam int SAMPLE_W     = FRAC_BITS + 1;
    localparam int WORD_W       = 32;
    localparam int MAX_CHANNELS = 8;

    // Configuration field widths
    localparam int FMT_W    = 2;
    localparam int NCH_W    = 4;
    localparam int FRAMES_W = 32;
    localparam int TARGET_W = 16;
    localparam int CFG_IDX_W = 2;

    // Front-end datapath widths
    localparam int POS_W       = 3;
    localparam int CH_SUM_W    = 27;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 30;
    localparam int PROD_W      = CH_SUM_W + RECIP_W;
    localparam int SQ_W        = 47;
    localparam int SQ_SUM_W    = 78;

    // Result widths
    localparam int COUNT_W  = 32;
    localparam int BLKNUM_W = 16;
    localparam int RMS_W    = 23;
    localparam int ROOT_W   = 24;
    localparam int RAD_W    = 2 * ROOT_W;

    // Block queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic signed [SAMPLE_W-1:0] FS_POS = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] FS_NEG = 24'sh800000;
    localparam logic [RMS_W-1:0]           RMS_MAX = 23'h7FFFFF;

    typedef enum logic [FMT_W-1:0] {
        FMT_S16 = 2'd0,
        FMT_S24 = 2'd1,
        FMT_S32 = 2'd2,
        FMT_F32 = 2'd3
    } sample_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_FORMAT = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_FRAME_COUNT   = 2'd2,
        REG_TARGET_BLOCKS = 2'd3
    } cfg_reg_t;

    // One closed block, handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] min_val;
        logic signed [SAMPLE_W-1:0] max_val;
        logic [SQ_SUM_W-1:0]        sq_sum;
        logic [COUNT_W-1:0]         count;
        logic [BLKNUM_W-1:0]        number;
        logic [FRAMES_W-1:0]        length;
        logic                       last;
    } block_rec_t;

    // Raw sample word to signed Q1.23
    function automatic logic signed [SAMPLE_W-1:0] to_q23(input sample_fmt_t fmt,
                                                           input logic [WORD_W-1:0] w);
        logic [7:0]                 ex;
        logic [7:0]                 rsh;
        logic [SAMPLE_W-1:0]        sig;
        logic [SAMPLE_W-1:0]        mag;
        logic signed [SAMPLE_W-1:0] res;
        ex  = w[30:23];
        rsh = 8'd127 - ex;
        sig = {1'b1, w[22:0]};
        mag = sig >> rsh[4:0];
        res = '0;
        case (fmt)
            FMT_S16: res = {w[15:0], 8'b0};
            FMT_S24: res = w[23:0];
            FMT_S32: res = w[31:8];
            FMT_F32:
            begin
                // NaN reads as zero; unity and above (and infinity) saturate
                if (ex == 8'hFF && w[22:0] != 23'd0)
                    res = '0;
                else if (ex >= 8'd127)
                    res = w[31] ? FS_NEG : FS_POS;
                else if (ex == 8'd0 || rsh >= 8'd25)
                    res = '0;
                else
                    res = w[31] ? -mag : mag;
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // ceil(2^30 / n): exact truncating divide by n for magnitudes below 2^27
    function automatic logic [RECIP_W-1:0] recip(input logic [NCH_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd2:    r = 31'd536870912;
            4'd3:    r = 31'd357913942;
            4'd4:    r = 31'd268435456;
            4'd5:    r = 31'd214748365;
            4'd6:    r = 31'd178956971;
            4'd7:    r = 31'd153391690;
            4'd8:    r = 31'd134217728;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/pbe_ifs.sv
// Valid/ready channel interfaces for samples in and block results out.
`default_nettype none

interface pbe_sample_if;
    logic                        valid;
    logic                        ready;
    logic [pbe_pkg::WORD_W-1:0]  sample_word;

    modport source (output valid, output sample_word, input ready);
    modport sink   (input valid, input sample_word, output ready);
endinterface

interface pbe_block_if;
    logic                                valid;
    logic                                ready;
    logic signed [pbe_pkg::SAMPLE_W-1:0] block_min;
    logic signed [pbe_pkg::SAMPLE_W-1:0] block_max;
    logic [pbe_pkg::RMS_W-1:0]           block_rms;
    logic [pbe_pkg::BLKNUM_W-1:0]        block_number;
    logic [pbe_pkg::FRAMES_W-1:0]        block_length;
    logic                                last_block;

    modport source (output valid, output block_min, output block_max, output block_rms,
                    output block_number, output block_length, output last_block,
                    input ready);
    modport sink   (input valid, input block_min, input block_max, input block_rms,
                    input block_number, input block_length, input last_block,
                    output ready);
endinterface

`default_nettype wire

### rtl/pbe_front.sv
// Front end: configuration, sample conversion, channel mixdown and block statistics.
`default_nettype none

module pbe_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pbe_sample_if.sink                         samples,
    input  wire logic                          cfg_we,
    input  wire logic [pbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbe_pkg::FRAMES_W-1:0]  cfg_data,
    input  wire logic                          pop,
    output logic                               push,
    output pbe_pkg::block_rec_t                push_rec
);

    typedef struct packed {
        logic                           close;
        logic                           last;
        logic [pbe_pkg::BLKNUM_W-1:0]   number;
        logic [pbe_pkg::COUNT_W-1:0]    count;
    } tag_t;

    // Configuration registers
    pbe_pkg::sample_fmt_t             fmt_reg;
    logic [pbe_pkg::NCH_W-1:0]        nch_reg;
    logic [pbe_pkg::FRAMES_W-1:0]     frames_reg;
    logic [pbe_pkg::TARGET_W-1:0]     target_reg;

    // Block length divider
    logic                             start_reg;
    logic                             busy_reg;
    logic [4:0]                       div_cnt_reg;
    logic [pbe_pkg::FRAMES_W-1:0]     div_rem_reg;
    logic [pbe_pkg::FRAMES_W-1:0]     div_quo_reg;
    logic [pbe_pkg::FRAMES_W-1:0]     blocks_reg;
    logic [pbe_pkg::FRAMES_W:0]       div_rem_sh;
    logic                             div_ge;
    logic [pbe_pkg::TARGET_W-1:0]     tgt_eff;
    logic [pbe_pkg::FRAMES_W-1:0]     blocks_calc;

    // Frame and block bookkeeping
    logic                             done_reg;
    logic [pbe_pkg::POS_W-1:0]        pos_reg;
    logic [pbe_pkg::COUNT_W-1:0]      fib_reg;
    logic [pbe_pkg::FRAMES_W-1:0]     fd_reg;
    logic [pbe_pkg::BLKNUM_W-1:0]     bc_reg;
    logic [pbe_pkg::QCNT_W-1:0]       credit_reg;
    logic [pbe_pkg::NCH_W-1:0]        nch_eff;
    logic [pbe_pkg::NCH_W-1:0]        nch_m1;
    logic [pbe_pkg::COUNT_W-1:0]      fib_inc;
    logic [pbe_pkg::FRAMES_W-1:0]     fd_inc;
    logic [pbe_pkg::BLKNUM_W:0]       bc_inc;
    logic                             accept;
    logic                             take;
    logic                             frame_end;
    logic                             is_last;
    logic                             closes;

    // Datapath pipeline
    logic                                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    tag_t                                   tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic                                   fe1_reg;
    logic signed [pbe_pkg::SAMPLE_W-1:0]    conv1_reg;
    logic signed [pbe_pkg::CH_SUM_W-1:0]    sum_reg;
    logic signed [pbe_pkg::CH_SUM_W-1:0]    sum_add;
    logic signed [pbe_pkg::CH_SUM_W-1:0]    tot2_reg;
    logic [pbe_pkg::CH_SUM_W-1:0]           abs2;
    logic                                   neg3_reg;
    logic [pbe_pkg::PROD_W-1:0]             prod3_reg;
    logic [pbe_pkg::SAMPLE_W-1:0]           q3;
    logic [pbe_pkg::SAMPLE_W-1:0]           mag4_reg;
    logic signed [pbe_pkg::SAMPLE_W-1:0]    mono4_reg;
    logic signed [pbe_pkg::SAMPLE_W-1:0]    run_min_reg, run_max_reg;
    logic signed [pbe_pkg::SAMPLE_W-1:0]    new_min, new_max;
    logic signed [pbe_pkg::SAMPLE_W-1:0]    min5_reg, max5_reg;
    logic [2*pbe_pkg::SAMPLE_W-1:0]         sq_full;
    logic [pbe_pkg::SQ_W-1:0]               sq5_reg;
    logic [pbe_pkg::SQ_SUM_W-1:0]           sq_sum_reg;
    logic [pbe_pkg::SQ_SUM_W-1:0]           sq_sum_add;

    // Effective channel count and block count
    always_comb
    begin
        if (nch_reg == '0)
            nch_eff = pbe_pkg::NCH_W'(1);
        else if (nch_reg > pbe_pkg::NCH_W'(pbe_pkg::MAX_CHANNELS))
            nch_eff = pbe_pkg::NCH_W'(pbe_pkg::MAX_CHANNELS);
        else
            nch_eff = nch_reg;
        nch_m1  = nch_eff - pbe_pkg::NCH_W'(1);
        tgt_eff = (target_reg == '0) ? pbe_pkg::TARGET_W'(1) : target_reg;
        if (pbe_pkg::FRAMES_W'(tgt_eff) < frames_reg)
            blocks_calc = pbe_pkg::FRAMES_W'(tgt_eff);
        else
            blocks_calc = frames_reg;
    end

    // Handshake and frame/block close decision
    assign samples.ready = !start_reg && !busy_reg &&
                           (credit_reg < pbe_pkg::QCNT_W'(pbe_pkg::QUEUE_DEPTH));
    assign accept    = samples.valid && samples.ready;
    assign take      = accept && !done_reg;
    assign frame_end = (pos_reg == nch_m1[pbe_pkg::POS_W-1:0]);
    assign fib_inc   = fib_reg + pbe_pkg::COUNT_W'(1);
    assign fd_inc    = fd_reg + pbe_pkg::FRAMES_W'(1);
    assign bc_inc    = {1'b0, bc_reg} + (pbe_pkg::BLKNUM_W + 1)'(1);
    assign is_last   = pbe_pkg::FRAMES_W'(bc_inc) >= blocks_reg;
    assign closes    = frame_end && (is_last ? (fd_inc == frames_reg) : (fib_inc == div_quo_reg));

    // Divider step
    assign div_rem_sh = {div_rem_reg, div_quo_reg[pbe_pkg::FRAMES_W-1]};
    assign div_ge     = div_rem_sh >= {1'b0, blocks_reg};

    // Configuration writes and block length divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= pbe_pkg::FMT_S16;
            nch_reg     <= pbe_pkg::NCH_W'(1);
            frames_reg  <= pbe_pkg::FRAMES_W'(1);
            target_reg  <= pbe_pkg::TARGET_W'(2000);
            start_reg   <= 1'b0;
            busy_reg    <= 1'b0;
            div_cnt_reg <= '0;
            div_rem_reg <= '0;
            div_quo_reg <= pbe_pkg::FRAMES_W'(1);
            blocks_reg  <= pbe_pkg::FRAMES_W'(1);
        end
        else
        begin
            start_reg <= cfg_we;
            if (cfg_we)
            begin
                busy_reg <= 1'b0;
                case (pbe_pkg::cfg_reg_t'(cfg_index))
                    pbe_pkg::REG_SAMPLE_FORMAT:
                        fmt_reg <= pbe_pkg::sample_fmt_t'(cfg_data[pbe_pkg::FMT_W-1:0]);
                    pbe_pkg::REG_CHANNEL_COUNT: nch_reg    <= cfg_data[pbe_pkg::NCH_W-1:0];
                    pbe_pkg::REG_FRAME_COUNT:   frames_reg <= cfg_data;
                    pbe_pkg::REG_TARGET_BLOCKS: target_reg <= cfg_data[pbe_pkg::TARGET_W-1:0];
                    default:                    fmt_reg    <= fmt_reg;
                endcase
            end
            else if (start_reg)
            begin
                blocks_reg  <= blocks_calc;
                div_quo_reg <= frames_reg;
                div_rem_reg <= '0;
                div_cnt_reg <= 5'd31;
                busy_reg    <= (frames_reg != '0);
            end
            else if (busy_reg)
            begin
                div_rem_reg <= div_ge ? pbe_pkg::FRAMES_W'(div_rem_sh - {1'b0, blocks_reg})
                                      : div_rem_sh[pbe_pkg::FRAMES_W-1:0];
                div_quo_reg <= {div_quo_reg[pbe_pkg::FRAMES_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Frame counters, block counter and queue credits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            pos_reg    <= '0;
            fib_reg    <= '0;
            fd_reg     <= '0;
            bc_reg     <= '0;
            credit_reg <= '0;
        end
        else if (cfg_we)
        begin
            done_reg   <= 1'b0;
            pos_reg    <= '0;
            fib_reg    <= '0;
            fd_reg     <= '0;
            bc_reg     <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (start_reg)
                done_reg <= (frames_reg == '0);
            if (take)
            begin
                if (frame_end)
                begin
                    pos_reg <= '0;
                    fd_reg  <= fd_inc;
                    if (closes)
                    begin
                        fib_reg <= '0;
                        bc_reg  <= bc_inc[pbe_pkg::BLKNUM_W-1:0];
                        if (is_last)
                            done_reg <= 1'b1;
                    end
                    else
                        fib_reg <= fib_inc;
                end
                else
                    pos_reg <= pos_reg + pbe_pkg::POS_W'(1);
            end
            if ((take && closes) && !pop)
                credit_reg <= credit_reg + pbe_pkg::QCNT_W'(1);
            else if (!(take && closes) && pop)
                credit_reg <= credit_reg - pbe_pkg::QCNT_W'(1);
        end
    end

    // Pipeline valids, channel sum, running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            sum_reg     <= '0;
            run_min_reg <= pbe_pkg::FS_POS;
            run_max_reg <= pbe_pkg::FS_NEG;
            sq_sum_reg  <= '0;
        end
        else if (cfg_we)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            sum_reg     <= '0;
            run_min_reg <= pbe_pkg::FS_POS;
            run_max_reg <= pbe_pkg::FS_NEG;
            sq_sum_reg  <= '0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg && fe1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (v1_reg)
                sum_reg <= fe1_reg ? '0 : sum_add;
            if (v4_reg)
            begin
                if (tag4_reg.close)
                begin
                    run_min_reg <= pbe_pkg::FS_POS;
                    run_max_reg <= pbe_pkg::FS_NEG;
                end
                else
                begin
                    run_min_reg <= new_min;
                    run_max_reg <= new_max;
                end
            end
            if (v5_reg)
                sq_sum_reg <= tag5_reg.close ? '0 : sq_sum_add;
        end
    end

    // Datapath arithmetic
    assign sum_add    = sum_reg + pbe_pkg::CH_SUM_W'(conv1_reg);
    assign abs2       = tot2_reg[pbe_pkg::CH_SUM_W-1] ? pbe_pkg::CH_SUM_W'(-tot2_reg)
                                                      : pbe_pkg::CH_SUM_W'(tot2_reg);
    assign q3         = prod3_reg[pbe_pkg::RECIP_SHIFT +: pbe_pkg::SAMPLE_W];
    assign new_min    = (mono4_reg < run_min_reg) ? mono4_reg : run_min_reg;
    assign new_max    = (mono4_reg > run_max_reg) ? mono4_reg : run_max_reg;
    assign sq_full    = mag4_reg * mag4_reg;
    assign sq_sum_add = sq_sum_reg + pbe_pkg::SQ_SUM_W'(sq5_reg);

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        // stage 1: convert
        conv1_reg <= pbe_pkg::to_q23(fmt_reg, samples.sample_word);
        fe1_reg   <= frame_end;
        tag1_reg  <= '{close: closes, last: is_last, number: bc_reg, count: fib_inc};
        // stage 2: frame total
        tot2_reg  <= sum_add;
        tag2_reg  <= tag1_reg;
        // stage 3: divide by channel count via reciprocal
        neg3_reg  <= tot2_reg[pbe_pkg::CH_SUM_W-1];
        prod3_reg <= abs2 * pbe_pkg::recip(nch_eff);
        tag3_reg  <= tag2_reg;
        // stage 4: signed mono value
        mag4_reg  <= q3;
        mono4_reg <= neg3_reg ? -q3 : q3;
        tag4_reg  <= tag3_reg;
        // stage 5: square, snapshot of min/max at block close
        sq5_reg   <= sq_full[pbe_pkg::SQ_W-1:0];
        min5_reg  <= new_min;
        max5_reg  <= new_max;
        tag5_reg  <= tag4_reg;
    end

    // Closed block into the queue
    assign push = v5_reg && tag5_reg.close;
    always_comb
    begin
        push_rec.min_val = min5_reg;
        push_rec.max_val = max5_reg;
        push_rec.sq_sum  = sq_sum_add;
        push_rec.count   = tag5_reg.count;
        push_rec.number  = tag5_reg.number;
        push_rec.length  = div_quo_reg;
        push_rec.last    = tag5_reg.last;
    end

endmodule

`default_nettype wire

### rtl/pbe_queue.sv
// Small block record queue between the front end and the back end.
`default_nettype none

module pbe_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire pbe_pkg::block_rec_t push_rec,
    input  wire logic                pop,
    output logic                     q_valid,
    output pbe_pkg::block_rec_t      q_rec
);

    pbe_pkg::block_rec_t              mem_reg [pbe_pkg::QUEUE_DEPTH];
    logic [pbe_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [pbe_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [pbe_pkg::QCNT_W-1:0]       count_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    // Pointers and fill level; the front end's credits keep it from overflowing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + pbe_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + pbe_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + pbe_pkg::QCNT_W'(1);
            else if (!push && pop)
                count_reg <= count_reg - pbe_pkg::QCNT_W'(1);
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_rec   = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### rtl/pbe_back.sv
// Back end: mean of squares by serial divide, integer square root, result register.
`default_nettype none

module pbe_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire pbe_pkg::block_rec_t q_rec,
    output logic                     pop,
    pbe_block_if.source              blocks
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_SQRT = 4'b0100,
        B_HOLD = 4'b1000
    } back_state_t;

    back_state_t                          state_reg, state_next;
    pbe_pkg::block_rec_t                  rec_reg;

    // Restoring divider: sum of squares / frames in block
    logic [6:0]                           div_cnt_reg;
    logic [pbe_pkg::COUNT_W-1:0]          div_rem_reg;
    logic [pbe_pkg::SQ_SUM_W-1:0]         div_quo_reg;
    logic [pbe_pkg::COUNT_W:0]            div_rem_sh;
    logic                                 div_ge;
    logic [pbe_pkg::SQ_SUM_W-1:0]         div_quo_next;

    // Two bits per step square root
    logic [4:0]                           sq_cnt_reg;
    logic [pbe_pkg::RAD_W-1:0]            sq_rad_reg;
    logic [pbe_pkg::ROOT_W+1:0]           sq_rem_reg;
    logic [pbe_pkg::ROOT_W-1:0]           sq_root_reg;
    logic [pbe_pkg::ROOT_W+1:0]           sq_rem_sh;
    logic [pbe_pkg::ROOT_W+1:0]           sq_trial;
    logic                                 sq_ge;

    // Result register
    logic                                 out_valid_reg;
    logic                                 load;
    logic [pbe_pkg::RMS_W-1:0]            rms;

    assign div_rem_sh   = {div_rem_reg, div_quo_reg[pbe_pkg::SQ_SUM_W-1]};
    assign div_ge       = div_rem_sh >= {1'b0, rec_reg.count};
    assign div_quo_next = {div_quo_reg[pbe_pkg::SQ_SUM_W-2:0], div_ge};

    assign sq_rem_sh = {sq_rem_reg[pbe_pkg::ROOT_W-1:0], sq_rad_reg[pbe_pkg::RAD_W-1 -: 2]};
    assign sq_trial  = {sq_root_reg, 2'b01};
    assign sq_ge     = sq_rem_sh >= sq_trial;

    assign pop  = (state_reg == B_IDLE) && q_valid;
    assign load = (state_reg == B_HOLD) && (!out_valid_reg || blocks.ready);
    assign rms  = sq_root_reg[pbe_pkg::ROOT_W-1] ? pbe_pkg::RMS_MAX
                                                 : sq_root_reg[pbe_pkg::RMS_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (q_valid) state_next = B_DIV;
            B_DIV:  if (div_cnt_reg == 7'd0) state_next = B_SQRT;
            B_SQRT: if (sq_cnt_reg == 5'd0) state_next = B_HOLD;
            B_HOLD: if (load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (blocks.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                rec_reg     <= q_rec;
                div_quo_reg <= q_rec.sq_sum;
                div_rem_reg <= '0;
                div_cnt_reg <= 7'(pbe_pkg::SQ_SUM_W - 1);
            end
            B_DIV:
            begin
                div_rem_reg <= div_ge ? pbe_pkg::COUNT_W'(div_rem_sh - {1'b0, rec_reg.count})
                                      : div_rem_sh[pbe_pkg::COUNT_W-1:0];
                div_quo_reg <= div_quo_next;
                div_cnt_reg <= div_cnt_reg - 7'd1;
                // mean never exceeds 2^46, so its low bits are the whole radicand
                sq_rad_reg  <= div_quo_next[pbe_pkg::RAD_W-1:0];
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= 5'(pbe_pkg::ROOT_W - 1);
            end
            B_SQRT:
            begin
                sq_rem_reg  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
                sq_root_reg <= {sq_root_reg[pbe_pkg::ROOT_W-2:0], sq_ge};
                sq_rad_reg  <= {sq_rad_reg[pbe_pkg::RAD_W-3:0], 2'b00};
                sq_cnt_reg  <= sq_cnt_reg - 5'd1;
            end
            default:
            begin
                sq_cnt_reg <= sq_cnt_reg;
            end
        endcase
        if (load)
        begin
            blocks.block_min    <= rec_reg.min_val;
            blocks.block_max    <= rec_reg.max_val;
            blocks.block_rms    <= rms;
            blocks.block_number <= rec_reg.number;
            blocks.block_length <= rec_reg.length;
            blocks.last_block   <= rec_reg.last;
        end
    end

    assign blocks.valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/pcm_block_envelope.sv
// Top level of the PCM block envelope: front end, block queue and back end.
//
// Samples arrive on the samples channel, one channel sample word per
// transaction, interleaved by frame. Each closed block leaves on the blocks
// channel as one transaction with min, max, RMS (unsigned Q0.23), block number,
// nominal length and a last-block flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); any
// write clears the track state. After a write, samples.ready stays low
// while the 32-step serial divider works out the block length.
// Reset loads the default registers with the length already known, so the
// block is ready for samples as soon as reset is released.
// Throughput: one sample per cycle, set by the front-end pipeline, while samples.ready
// is high. The back end takes one block at a time: a 78-step divide of the square
// sum by the block's frame count, then a 24-step square root. The input stalls once
// four closed blocks wait on it. A stalled receiver holds the result register; the
// back end then waits, the queue fills and the input stalls.
`default_nettype none

module pcm_block_envelope (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pbe_sample_if.sink                         samples,
    pbe_block_if.source                        blocks,
    input  wire logic                          cfg_we,
    input  wire logic [pbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbe_pkg::FRAMES_W-1:0]  cfg_data
);

    logic                   push;
    logic                   pop;
    logic                   q_valid;
    pbe_pkg::block_rec_t    push_rec;
    pbe_pkg::block_rec_t    q_rec;

    // Sample intake and per-block statistics
    pbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop       (pop),
        .push      (push),
        .push_rec  (push_rec)
    );

    // Closed blocks waiting for the back end
    pbe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_rec    (q_rec)
    );

    // RMS computation and result output
    pbe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_rec   (q_rec),
        .pop     (pop),
        .blocks  (blocks)
    );

endmodule

`default_nettype wire

### test/pbe_envelope_checker.sv
// Passive checker: predicts block envelopes from the sample stream and compares block results.
module pbe_envelope_checker
    import pbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pbe_sample_if                samples,
    pbe_block_if                 blocks,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAMES_W-1:0]  cfg_data,
    output int                   due_count,
    output int                   fail_count
);

    localparam longint Q_POS = (longint'(1) << FRAC_BITS) - 1;
    localparam longint Q_NEG = -(longint'(1) << FRAC_BITS);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic [RMS_W-1:0]           rms;
        logic [BLKNUM_W-1:0]        num;
        logic [FRAMES_W-1:0]        len;
        logic                       last;
    } envelope_t;

    // Shadow copy of the configuration registers
    sample_fmt_t         fmt;
    logic [NCH_W-1:0]    nch_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [TARGET_W-1:0] target_reg;

    // Track and block accumulators
    int                  chan_pos;
    longint              chan_sum;
    longint unsigned     frames_in_block;
    longint unsigned     frames_done;
    logic [BLKNUM_W-1:0] block_no;
    longint              run_min;
    longint              run_max;
    logic [127:0]        energy;

    envelope_t envelopes_due[$];
    int        errors;

    // IEEE single to Q1.23: NaN and denormals read as zero, unity and above saturate
    function automatic longint float_to_q(logic [WORD_W-1:0] w);
        int     shift;
        longint mag;
        shift = int'(w[30:23]) - 127;
        if (w[30:23] == 8'hFF && w[22:0] != '0)
            return 0;
        if (w[30:23] == 8'h00)
            return 0;
        if (shift >= 0)
            return w[31] ? Q_NEG : Q_POS;
        if (shift <= -25)
            return 0;
        mag = longint'({1'b1, w[22:0]}) >> (-shift);
        return w[31] ? -mag : mag;
    endfunction

    function automatic longint word_to_q(sample_fmt_t f, logic [WORD_W-1:0] w);
        logic signed [15:0] s16;
        logic signed [23:0] s24;
        logic signed [31:0] s32;
        longint             v;
        s16 = w[15:0];
        s24 = w[23:0];
        s32 = w;
        case (f)
            // Q1.15 widened to Q1.23
            FMT_S16: v = longint'(s16) * 256;
            FMT_S24: v = longint'(s24);
            // Q1.31 narrowed with floor
            FMT_S32: v = longint'(s32) >>> 8;
            default: v = float_to_q(w);
        endcase
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        int              b;
        r = 0;
        for (b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function void open_block();
        frames_in_block = 0;
        run_min         = Q_POS;
        run_max         = Q_NEG;
        energy          = '0;
    endfunction

    function void restart_track();
        chan_pos    = 0;
        chan_sum    = 0;
        block_no    = '0;
        frames_done = 0;
        open_block();
    endfunction

    // Any register write starts a new track
    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [FRAMES_W-1:0] data);
        case (cfg_reg_t'(idx))
            REG_SAMPLE_FORMAT: fmt = sample_fmt_t'(data[FMT_W-1:0]);
            REG_CHANNEL_COUNT: nch_reg = data[NCH_W-1:0];
            REG_FRAME_COUNT:   frames_reg = data;
            default:           target_reg = data[TARGET_W-1:0];
        endcase
        restart_track();
    endfunction

    // Fold one accepted sample into the track; queue a result when a block closes
    function void accumulate_sample(logic [WORD_W-1:0] w);
        longint unsigned eff;
        longint unsigned tgt;
        longint unsigned nblocks;
        longint unsigned len;
        longint unsigned sq;
        longint unsigned mean;
        longint unsigned root;
        longint          mono;
        longint          mag;
        bit              last_blk;
        bit              closing;
        envelope_t       e;

        eff = (nch_reg == 0) ? 1 : ((nch_reg > MAX_CHANNELS) ? MAX_CHANNELS : nch_reg);
        tgt = (target_reg == 0) ? 1 : target_reg;
        if (frames_reg == 0 || frames_done >= frames_reg)
            return;

        chan_sum += word_to_q(fmt, w);
        chan_pos++;
        if (chan_pos < eff)
            return;

        // Mono average truncates toward zero
        mono     = chan_sum / longint'(eff);
        chan_pos = 0;
        chan_sum = 0;

        if (mono < run_min)
            run_min = mono;
        if (mono > run_max)
            run_max = mono;
        mag    = (mono < 0) ? -mono : mono;
        sq     = mag * mag;
        energy = energy + sq;
        frames_in_block++;
        frames_done++;

        nblocks  = (tgt < frames_reg) ? tgt : frames_reg;
        len      = frames_reg / nblocks;
        last_blk = (longint'(block_no) + 1) >= nblocks;
        closing  = last_blk ? (frames_done >= frames_reg) : (frames_in_block >= len);
        if (!closing)
            return;

        mean = 64'(energy / frames_in_block);
        root = floor_sqrt(mean);
        if (root > Q_POS)
            root = Q_POS;

        e.lo   = run_min[SAMPLE_W-1:0];
        e.hi   = run_max[SAMPLE_W-1:0];
        e.rms  = root[RMS_W-1:0];
        e.num  = block_no;
        e.len  = len[FRAMES_W-1:0];
        e.last = last_blk;
        envelopes_due.insert(envelopes_due.size(), e);

        block_no++;
        open_block();
    endfunction

    function void check_result();
        envelope_t got;
        envelope_t want;
        got.lo   = blocks.block_min;
        got.hi   = blocks.block_max;
        got.rms  = blocks.block_rms;
        got.num  = blocks.block_number;
        got.len  = blocks.block_length;
        got.last = blocks.last_block;

        if (envelopes_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected block transaction: num %0d min %0d max %0d rms %0d",
                         got.num, got.lo, got.hi, got.rms);
            return;
        end

        want = envelopes_due.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("block mismatch: expected min %0d max %0d rms %0d num %0d len %0d last %0d",
                         want.lo, want.hi, want.rms, want.num, want.len, want.last);
                $display("                actual   min %0d max %0d rms %0d num %0d len %0d last %0d",
                         got.lo, got.hi, got.rms, got.num, got.len, got.last);
            end
        end
    endfunction

    // Results are checked before new samples so that a stray result never pairs with a fresh block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt        = FMT_S16;
            nch_reg    = 4'd1;
            frames_reg = 32'd1;
            target_reg = 16'd2000;
            restart_track();
            envelopes_due.delete();
            errors = 0;
            due_count  <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (blocks.valid && blocks.ready)
                check_result();
            if (samples.valid && samples.ready)
                accumulate_sample(samples.sample_word);
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
            due_count  <= envelopes_due.size();
            fail_count <= errors;
        end
    end

endmodule

### test/tb_pcm_block_envelope.sv
// Testbench top for the PCM block envelope: clock, reset, stimulus, flow control and verdict.
module tb_pcm_block_envelope;
    import pbe_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 160;
    localparam int HOLD_CYCLES  = 1500;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FRAMES_W-1:0]  cfg_data;
    int                   due_count;
    int                   fail_count;

    bit hold_req;
    bit steady;
    int burst_left;
    int random_items;

    pbe_sample_if sample_ch();
    pbe_block_if  block_ch();

    pcm_block_envelope u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .blocks    (block_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pbe_envelope_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (sample_ch),
        .blocks     (block_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .due_count  (due_count),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Back-to-back register writes; write enable drops after the last one
    task automatic load_track(input sample_fmt_t f, input logic [NCH_W-1:0] nch,
                              input logic [FRAMES_W-1:0] frames,
                              input logic [TARGET_W-1:0] target);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SAMPLE_FORMAT;
        cfg_data  <= FRAMES_W'(f);
        @(posedge clk);
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= FRAMES_W'(nch);
        @(posedge clk);
        cfg_index <= REG_FRAME_COUNT;
        cfg_data  <= frames;
        @(posedge clk);
        cfg_index <= REG_TARGET_BLOCKS;
        cfg_data  <= FRAMES_W'(target);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One sample transaction; bursts of random length with random gaps unless steady
    task automatic send_sample(input logic [WORD_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        sample_ch.valid       <= 1'b1;
        sample_ch.sample_word <= w;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Stop sending, wait for every expected block, then let the back end go quiet
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sample word biased toward the extremes of the given format
    function automatic logic [WORD_W-1:0] pick_word(input sample_fmt_t f);
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] specials [0:10];
        int                r;
        int                v;
        specials = '{32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                     32'h3F80_0000, 32'hBF80_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
                     32'h007F_FFFF, 32'h8000_0000, 32'h3400_0000};
        r = $urandom_range(0, 9);
        w = $urandom;
        if (r == 0)
            return w;
        if (r <= 2)
        begin
            case (f)
                FMT_S16: w[15:0] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                FMT_S24: w[23:0] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                FMT_S32: w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: w = specials[$urandom_range(0, 10)];
            endcase
            return w;
        end
        if (r == 3)
        begin
            v = $urandom_range(0, 6) - 3;
            case (f)
                FMT_S16: w[15:0] = 16'(v);
                FMT_S24: w[23:0] = 24'(v);
                FMT_S32: w = 32'(v);
                default: w = {1'($urandom), 8'($urandom_range(0, 1)), 23'($urandom)};
            endcase
            return w;
        end
        if (f == FMT_F32)
            w = {1'($urandom), 8'($urandom_range(100, 127)), 23'($urandom)};
        return w;
    endfunction

    // Result receiver: rotating stall patterns, plus one long hold on request
    initial
    begin
        int tick;
        tick = 0;
        block_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                block_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case ((tick / 300) % 4)
                    0:       block_ch.ready <= 1'b1;
                    1:       block_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       block_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: block_ch.ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (block_ch.valid && block_ch.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        sample_fmt_t f;
        int          nch;
        int          eff;
        int          frames;
        int          nominal;
        int          sent;
        int          r;
        logic [TARGET_W-1:0] target;

        sample_ch.valid       <= 1'b0;
        sample_ch.sample_word <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_SAMPLE_FORMAT;
        cfg_data              <= '0;
        rst_n                 <= 1'b0;
        hold_req     = 1'b0;
        steady       = 1'b1;
        burst_left   = 0;
        random_items = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: one frame, one block; the second sample comes after the track ends
        send_sample(32'h0000_7FFF);
        send_sample(32'h1234_8000);
        settle();

        // S16 stereo, two blocks of two frames, with junk in the unused upper half
        load_track(FMT_S16, 4'd2, 32'd4, 16'd2);
        send_sample(32'hFFFF_7FFF);
        send_sample(32'h0000_7FFF);
        send_sample(32'hA5A5_8000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'h7FFF_0000);
        send_sample(32'h8000_FFFF);
        settle();

        // S24 at negative full scale: RMS saturates; zero target acts as one block
        load_track(FMT_S24, 4'd1, 32'd3, 16'd0);
        send_sample(32'hFF80_0000);
        send_sample(32'h0080_0000);
        send_sample(32'h1280_0000);
        settle();

        // S32, three channels in one frame, target above the frame count
        load_track(FMT_S32, 4'd3, 32'd1, 16'd5);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_00FF);
        settle();

        // F32: NaN, infinities, denormal, unity, minus one half, a value just below unity and tiny ones
        load_track(FMT_F32, 4'd1, 32'd10, 16'd3);
        send_sample(32'h7FC0_0000);
        send_sample(32'h7F80_0000);
        send_sample(32'hFF80_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h3F80_0000);
        send_sample(32'hBF00_0000);
        send_sample(32'h3F7F_FFFF);
        send_sample(32'h3300_0000);
        send_sample(32'h3400_0000);
        send_sample(32'h8000_0000);
        settle();

        // Largest target with a large frame count: blocks of 100 frames, first two sent
        steady = 1'b0;
        load_track(FMT_S32, 4'd1, 32'd6553599, 16'hFFFF);
        repeat (200) send_sample(pick_word(FMT_S32));
        settle();

        // One-frame blocks pile up behind a long receiver hold until the input stalls,
        // then the sender pauses mid-track until every block has come out
        steady = 1'b1;
        load_track(FMT_S24, 4'd1, 32'd40, 16'd40);
        hold_req = 1'b1;
        repeat (20) send_sample(pick_word(FMT_S24));
        settle();
        repeat (20) send_sample(pick_word(FMT_S24));
        settle();

        // Random tracks: mostly complete, some with trailing samples, some cut short
        while (random_items < RANDOM_ITEMS)
        begin
            f = sample_fmt_t'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 90)
                nch = $urandom_range(1, 8);
            else if (r < 94)
                nch = 0;
            else
                nch = $urandom_range(9, 15);
            eff = (nch == 0) ? 1 : ((nch > MAX_CHANNELS) ? MAX_CHANNELS : nch);

            r = $urandom_range(0, 99);
            if (r < 6)
                frames = 0;
            else if (r < 80)
                frames = $urandom_range(1, 16);
            else
                frames = $urandom_range(17, 48);

            r = $urandom_range(0, 99);
            if (r < 8)
                target = '0;
            else if (r < 15)
                target = 16'hFFFF;
            else if (r < 25)
                target = 16'($urandom);
            else
                target = 16'($urandom_range(1, frames + 2));

            nominal = frames * eff;
            r = $urandom_range(0, 99);
            if (frames == 0)
                sent = $urandom_range(1, 10);
            else if (r < 82)
                sent = nominal;
            else if (r < 92)
                sent = nominal + $urandom_range(1, 5);
            else
                sent = $urandom_range(0, nominal - 1);

            steady = ($urandom_range(0, 3) == 0);
            load_track(f, 4'(nch), 32'(frames), target);
            repeat (sent) send_sample(pick_word(f));
            random_items += (sent < nominal) ? sent : nominal;
            settle();
        end

        if (fail_count == 0 && due_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### pcm_block_envelope.f
rtl/pbe_pkg.sv
rtl/pbe_ifs.sv
rtl/pbe_front.sv
rtl/pbe_queue.sv
rtl/pbe_back.sv
rtl/pcm_block_envelope.sv
test/pbe_envelope_checker.sv
test/tb_pcm_block_envelope.sv
